>>> rtl/bcgd_pkg.sv
package bcgd_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned HoldW    = 4;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegPollPeriod  = 4'd0;
  localparam logic [CfgAddrW-1:0] RegShortLimit  = 4'd1;
  localparam logic [CfgAddrW-1:0] RegClickWindow = 4'd2;
  localparam logic [CfgAddrW-1:0] RegHoldTime0   = 4'd3;
  localparam logic [CfgAddrW-1:0] RegHoldTime1   = 4'd4;
  localparam logic [CfgAddrW-1:0] RegHoldTime2   = 4'd5;
  localparam logic [CfgAddrW-1:0] RegHoldTime3   = 4'd6;
  localparam logic [CfgAddrW-1:0] RegHoldMask    = 4'd7;

  localparam logic [7:0]  PollPeriodRst  = 8'd25;
  localparam logic [15:0] ShortLimitRst  = 16'd500;
  localparam logic [15:0] ClickWindowRst = 16'd250;
  localparam logic [15:0] HoldTime0Rst   = 16'd1000;
  localparam logic [15:0] HoldTime1Rst   = 16'd2000;
  localparam logic [15:0] HoldTime2Rst   = 16'd3000;
  localparam logic [15:0] HoldTime3Rst   = 16'd5000;

  typedef struct packed {
    logic [7:0]             poll_period;
    logic [15:0]            short_limit;
    logic [15:0]            click_window;
    logic [HoldW-1:0][15:0] hold_time;
    logic [HoldW-1:0]       hold_mask;
  } cfg_t;

  typedef struct packed {
    logic             press_active;
    logic [15:0]      press_elapsed;
    logic [7:0]       poll_countdown;
    logic [1:0]       click_count;
    logic             window_active;
    logic [15:0]      window_remaining;
    logic [HoldW-1:0] hold_fired;
  } state_t;

  typedef struct packed {
    logic             is_pressed;
    logic [HoldW-1:0] hold_events;
    logic             release_event;
    logic             double_click_event;
    logic             click_event;
  } result_t;

endpackage

>>> rtl/bcgd_step.sv
module bcgd_step import bcgd_pkg::*; #(
  parameter int unsigned HOLD_SLOTS = 4
) (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  logic    level_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [7:0]  reload;
  logic [15:0] elapsed;
  logic [1:0]  count;

  // a zero poll period samples every tick
  assign reload = (cfg_i.poll_period == 8'd0) ? 8'd1 : cfg_i.poll_period;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    elapsed  = state_i.press_elapsed;
    count    = state_i.click_count;

    // window expiry goes first
    if (state_i.window_active) begin
      if (state_i.window_remaining <= 16'd1) begin
        state_o.window_remaining = '0;
        state_o.window_active    = 1'b0;
        result_o.click_event     = (state_i.click_count == 2'd1);
        state_o.click_count      = '0;
      end else begin
        state_o.window_remaining = state_i.window_remaining - 16'd1;
      end
    end

    if (state_i.press_active) begin
      if (state_i.press_elapsed != 16'hFFFF) begin
        elapsed = state_i.press_elapsed + 16'd1;
      end
      state_o.press_elapsed = elapsed;
      if (state_i.poll_countdown <= 8'd1) begin
        state_o.poll_countdown = reload;
        if (!level_i) begin
          for (int i = 0; i < HOLD_SLOTS; i++) begin
            if (cfg_i.hold_mask[i] && !state_i.hold_fired[i] &&
                elapsed >= cfg_i.hold_time[i]) begin
              result_o.hold_events[i] = 1'b1;
              state_o.hold_fired[i]   = 1'b1;
            end
          end
        end else begin
          state_o.press_active = 1'b0;
          if (elapsed < cfg_i.short_limit) begin
            count = state_o.click_count + 2'd1;
            if (count == 2'd1) begin
              state_o.click_count      = count;
              state_o.window_active    = 1'b1;
              state_o.window_remaining = cfg_i.click_window;
            end else begin
              state_o.click_count         = '0;
              state_o.window_active       = 1'b0;
              state_o.window_remaining    = '0;
              result_o.double_click_event = 1'b1;
            end
          end else begin
            result_o.release_event = 1'b1;
          end
          state_o.hold_fired = '0;
        end
      end else begin
        state_o.poll_countdown = state_i.poll_countdown - 8'd1;
      end
    end else if (!level_i) begin
      state_o.press_active   = 1'b1;
      state_o.press_elapsed  = '0;
      state_o.poll_countdown = reload;
    end

    result_o.is_pressed = state_o.press_active;
  end

endmodule

>>> rtl/button_click_gesture_detector.sv
// Button gesture detector: each request on the input stream is one 1 ms tick
// carrying the active-low pin level and gives exactly one result in the next
// cycle with the click, double-click, long-release and hold flags plus the
// press state. A tick is taken every clock cycle; the single output register
// holds a result while the sink stalls, and the input is then held off until
// it is taken. The user must write registers via the cfg port only while the
// stream is idle; the block does not check. Reset: 25 ms poll period, 500 ms
// short-press limit, 250 ms double-click window, 1/2/3/5 s holds, all off.
module button_click_gesture_detector import bcgd_pkg::*; #(
  parameter int unsigned HOLD_SLOTS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [0] button_level, rest zero
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] click_event, [1] double_click_event, [2] release_event,
  // [6:3] hold_events, [7] is_pressed
  output logic [7:0]          m_axis_tdata_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    in_req;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_req          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_period  <= PollPeriodRst;
      cfg_q.short_limit  <= ShortLimitRst;
      cfg_q.click_window <= ClickWindowRst;
      cfg_q.hold_time[0] <= HoldTime0Rst;
      cfg_q.hold_time[1] <= HoldTime1Rst;
      cfg_q.hold_time[2] <= HoldTime2Rst;
      cfg_q.hold_time[3] <= HoldTime3Rst;
      cfg_q.hold_mask    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegPollPeriod:  cfg_q.poll_period  <= cfg_wdata_i[7:0];
        RegShortLimit:  cfg_q.short_limit  <= cfg_wdata_i;
        RegClickWindow: cfg_q.click_window <= cfg_wdata_i;
        RegHoldTime0:   cfg_q.hold_time[0] <= cfg_wdata_i;
        RegHoldTime1:   cfg_q.hold_time[1] <= cfg_wdata_i;
        RegHoldTime2:   cfg_q.hold_time[2] <= cfg_wdata_i;
        RegHoldTime3:   cfg_q.hold_time[3] <= cfg_wdata_i;
        RegHoldMask:    cfg_q.hold_mask    <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  bcgd_step #(
    .HOLD_SLOTS (HOLD_SLOTS)
  ) u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .level_i  (s_axis_tdata_i[0]),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_req) begin
        state_q <= state_d;
      end
      if (in_req) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {result_q.is_pressed, result_q.hold_events,
                            result_q.release_event, result_q.double_click_event,
                            result_q.click_event};

endmodule

>>> rtl/bcgd_checker.sv
module bcgd_checker import bcgd_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [7:0]          m_axis_tdata_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // with nothing pending the block must take a request
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input held off with empty output");

  // double click and long release never come from the same release
  a_dbl_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[1] && m_axis_tdata_o[2]))
    else $error("double click and release together");

  // a release of either kind ends the press
  a_rel_unpressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1] || m_axis_tdata_o[2]) |-> !m_axis_tdata_o[7])
    else $error("release seen while still pressed");

  // holds only fire during a press
  a_hold_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[6:3] != 4'd0) |-> m_axis_tdata_o[7])
    else $error("hold event outside a press");

endmodule

bind button_click_gesture_detector bcgd_checker u_bcgd_checker (.*);

>>> bench/tb_button_click_gesture_detector.sv
module tb_button_click_gesture_detector;
  import bcgd_pkg::*;

  localparam int unsigned HOLD_SLOTS   = 4;
  localparam int          LIMIT_CYCLES = 1_000_000;
  // indexes from here up address no register
  localparam logic [CfgAddrW-1:0] RegSpareLo = 4'd8;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i  = '0;  // [0] button_level, rest zero
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [0] click_event, [1] double_click_event, [2] release_event,
  // [6:3] hold_events, [7] is_pressed
  logic [7:0]          m_axis_tdata_o;

  button_click_gesture_detector #(
    .HOLD_SLOTS(HOLD_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // register copies, reset values
  logic [7:0]            cfg_poll   = PollPeriodRst;
  logic [15:0]           cfg_short  = ShortLimitRst;
  logic [15:0]           cfg_window = ClickWindowRst;
  logic [15:0]           cfg_hold [HOLD_SLOTS] =
    '{HoldTime0Rst, HoldTime1Rst, HoldTime2Rst, HoldTime3Rst};
  logic [HOLD_SLOTS-1:0] cfg_mask   = '0;

  // gesture state
  logic                  st_pressed  = 1'b0;
  logic [15:0]           st_elapsed  = '0;
  logic [7:0]            st_poll     = '0;
  logic [1:0]            st_clicks   = '0;
  logic                  st_win_on   = 1'b0;
  logic [15:0]           st_win_left = '0;
  logic [HOLD_SLOTS-1:0] st_fired    = '0;

  result_t pending_gestures [$];
  int      error_count    = 0;
  int      cycle_count    = 0;
  int      send_idle_pct  = 0;
  int      recv_stall_pct = 0;
  result_t want, got;

  function automatic result_t advance_gesture(input logic level_high);
    result_t r;
    r = '0;
    // window expiry comes ahead of the press handling
    if (st_win_on) begin
      if (st_win_left <= 16'd1) begin
        st_win_left = '0;
        st_win_on   = 1'b0;
        if (st_clicks == 2'd1) r.click_event = 1'b1;
        st_clicks = '0;
      end else begin
        st_win_left = st_win_left - 16'd1;
      end
    end
    if (st_pressed) begin
      if (st_elapsed != 16'hFFFF) st_elapsed = st_elapsed + 16'd1;
      if (st_poll <= 8'd1) begin
        st_poll = (cfg_poll == 8'd0) ? 8'd1 : cfg_poll;
        if (!level_high) begin
          for (int i = 0; i < HOLD_SLOTS; i++) begin
            if (cfg_mask[i] && !st_fired[i] && st_elapsed >= cfg_hold[i]) begin
              r.hold_events[i] = 1'b1;
              st_fired[i]      = 1'b1;
            end
          end
        end else begin
          st_pressed = 1'b0;
          if (st_elapsed < cfg_short) begin
            st_clicks = st_clicks + 2'd1;
            if (st_clicks == 2'd1) begin
              st_win_on   = 1'b1;
              st_win_left = cfg_window;
            end else begin
              st_win_on            = 1'b0;
              st_win_left          = '0;
              r.double_click_event = 1'b1;
              st_clicks            = '0;
            end
          end else begin
            r.release_event = 1'b1;
          end
          st_fired = '0;
        end
      end else begin
        st_poll = st_poll - 8'd1;
      end
    end else if (!level_high) begin
      st_pressed = 1'b1;
      st_elapsed = '0;
      st_poll    = (cfg_poll == 8'd0) ? 8'd1 : cfg_poll;
    end
    r.is_pressed = st_pressed;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("click=%0b dbl=%0b rel=%0b hold=%h pressed=%0b",
                     r.click_event, r.double_click_event, r.release_event,
                     r.hold_events, r.is_pressed);
  endfunction

  function automatic void log_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_button_click_gesture_detector: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o);
      if (pending_gestures.size() == 0) begin
        log_error($sformatf("unexpected result %s", show(got)));
      end else begin
        want = pending_gestures.pop_front();
        if (got.click_event !== want.click_event ||
            got.double_click_event !== want.double_click_event ||
            got.release_event !== want.release_event ||
            got.hold_events !== want.hold_events ||
            got.is_pressed !== want.is_pressed) begin
          log_error($sformatf("expected %s, got %s", show(want), show(got)));
        end
      end
    end
  end

  // valid stays high after a request so back-to-back ticks need no toggle
  task automatic send_tick(input logic level_high);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, level_high};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_gestures = {pending_gestures, advance_gesture(level_high)};
  endtask

  // must follow the last send_tick in the same step
  task automatic sender_quiet();
    s_axis_tvalid_i <= 1'b0;
    while (pending_gestures.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr,
                           input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (addr)
      RegPollPeriod:  cfg_poll    = data[7:0];
      RegShortLimit:  cfg_short   = data;
      RegClickWindow: cfg_window  = data;
      RegHoldTime0:   cfg_hold[0] = data;
      RegHoldTime1:   cfg_hold[1] = data;
      RegHoldTime2:   cfg_hold[2] = data;
      RegHoldTime3:   cfg_hold[3] = data;
      RegHoldMask:    cfg_mask    = data[HOLD_SLOTS-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly press/release runs with random lengths, some single noisy ticks
  task automatic drive_gestures(input int n, input int press_max, input int gap_max);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 80) begin
        len = $urandom_range(press_max, 1);
        repeat (len) send_tick(1'b0);
        sent += len;
        len = $urandom_range(gap_max, 1);
        repeat (len) send_tick(1'b1);
        sent += len;
      end else begin
        send_tick(1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  task automatic test_defaults();
    send_tick(1'b0);
    repeat (25) send_tick(1'b1);
    sender_quiet();
  endtask

  task automatic test_clicks();
    write_reg(RegPollPeriod, 16'd1);
    write_reg(RegShortLimit, 16'd4);
    write_reg(RegClickWindow, 16'd6);
    write_reg(RegHoldMask, 16'd0);
    // two quick presses: double click
    send_tick(1'b0); send_tick(1'b0); send_tick(1'b1); send_tick(1'b1);
    send_tick(1'b0); send_tick(1'b1);
    repeat (2) send_tick(1'b1);
    // lone press: click once the window runs out
    send_tick(1'b0);
    repeat (8) send_tick(1'b1);
    // long press
    repeat (5) send_tick(1'b0);
    send_tick(1'b1);
    sender_quiet();
  endtask

  task automatic test_holds();
    write_reg(RegPollPeriod, 16'hA502);
    write_reg(RegShortLimit, 16'd3);
    write_reg(RegHoldTime0, 16'd0);
    write_reg(RegHoldTime1, 16'd2);
    write_reg(RegHoldTime2, 16'd4);
    write_reg(RegHoldTime3, 16'hFFFF);
    write_reg(RegHoldMask, 16'hFFFF);
    repeat (9) send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    sender_quiet();
  endtask

  task automatic test_zero_settings();
    write_reg(RegPollPeriod, 16'hFF00);
    write_reg(RegShortLimit, 16'd0);
    write_reg(RegClickWindow, 16'd0);
    send_tick(1'b0); send_tick(1'b1); send_tick(1'b1);
    sender_quiet();
    write_reg(RegShortLimit, 16'd3);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    sender_quiet();
    // writes past the last register must change nothing
    write_reg(RegSpareLo + 4'($urandom_range(7)), 16'($urandom));
    write_reg(RegSpareLo + 4'd7, 16'hFFFF);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    sender_quiet();
  endtask

  task automatic test_random_gestures();
    int          send_pct [4] = '{0, 86, 0, 25};
    int          recv_pct [4] = '{0, 0, 86, 25};
    logic [15:0] short_v;
    logic [15:0] win_v;
    for (int m = 0; m < 4; m++) begin
      for (int c = 0; c < 2; c++) begin
        sender_quiet();
        short_v = 16'($urandom_range(12, 2));
        win_v   = 16'($urandom_range(20, 1));
        write_reg(RegPollPeriod, {8'($urandom), 8'($urandom_range(4, 1))});
        write_reg(RegShortLimit, short_v);
        write_reg(RegClickWindow, win_v);
        write_reg(RegHoldTime0, 16'($urandom_range(30)));
        write_reg(RegHoldTime1, 16'($urandom_range(30)));
        write_reg(RegHoldTime2, 16'($urandom_range(30)));
        write_reg(RegHoldTime3, 16'($urandom_range(30)));
        write_reg(RegHoldMask, 16'($urandom));
        send_idle_pct  = send_pct[m];
        recv_stall_pct = recv_pct[m];
        drive_gestures(70, 3 * short_v + 10, 2 * win_v + 4);
      end
    end
    sender_quiet();
  endtask

  task automatic test_extreme_settings();
    write_reg(RegPollPeriod, 16'd255);
    write_reg(RegShortLimit, 16'd1);
    write_reg(RegClickWindow, 16'd1);
    write_reg(RegHoldTime0, 16'd0);
    write_reg(RegHoldTime1, 16'hFFFF);
    write_reg(RegHoldTime2, 16'd1);
    write_reg(RegHoldTime3, 16'd255);
    write_reg(RegHoldMask, 16'd15);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    drive_gestures(150, 300, 100);
    sender_quiet();
    write_reg(RegPollPeriod, 16'd1);
    write_reg(RegShortLimit, 16'hFFFF);
    write_reg(RegClickWindow, 16'hFFFF);
    write_reg(RegHoldTime0, 16'hFFFF);
    write_reg(RegHoldTime1, 16'd0);
    write_reg(RegHoldTime2, 16'd3);
    write_reg(RegHoldMask, 16'd6);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drive_gestures(60, 6, 6);
    sender_quiet();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_clicks();
    test_holds();
    test_zero_settings();
    test_random_gestures();
    test_extreme_settings();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_button_click_gesture_detector: done, clean");
    end else begin
      $display("tb_button_click_gesture_detector: done, errors");
    end
    $finish;
  end

endmodule

>>> button_click_gesture_detector.f
rtl/bcgd_pkg.sv
rtl/bcgd_step.sv
rtl/button_click_gesture_detector.sv
rtl/bcgd_checker.sv
bench/tb_button_click_gesture_detector.sv
